### hw/rtl/sstp_pkg.sv
// ----------------------------------------------------------------------------
// Sprite sheet tile packer package
// Shared widths, register indexes, configuration and stage types, and the
// grid sizing function used by the packer core.
// ----------------------------------------------------------------------------
package sstp_pkg;

	localparam int MAX_TILE_DIM    = 1024;
	localparam int MAX_TILES       = 256;
	localparam int MAX_SIDE        = 16;
	localparam int BYTES_PER_PIXEL = 4;

	localparam int DIM_W  = 11;
	localparam int CNT_W  = 9;
	localparam int GRID_W = 5;
	localparam int COL_W  = 4;
	localparam int ROW_W  = 9;
	localparam int PIX_W  = 10;
	localparam int CH_W   = 2;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 30;
	localparam int IDX_W  = 2;

	// Row and column coordinates in the sheet and the sheet width in pixels.
	localparam int Y_W  = 21;
	localparam int X_W  = 16;
	localparam int SW_W = 16;
	localparam int LIN_W = ADDR_W - CH_W;

	typedef logic [IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_TILE_WIDTH  = 2'd0;
	localparam reg_idx_t REG_TILE_HEIGHT = 2'd1;
	localparam reg_idx_t REG_TILE_COUNT  = 2'd2;

	localparam logic [CH_W-1:0] LAST_CHANNEL = CH_W'(BYTES_PER_PIXEL - 1);

	typedef struct packed {
		logic [GRID_W-1:0] cols;
		logic [GRID_W-1:0] rows;
	} grid_t;

	// Clamped configuration as seen by the datapath.
	typedef struct packed {
		logic [DIM_W-1:0]  tile_w;
		logic [DIM_W-1:0]  tile_h;
		logic [CNT_W-1:0]  count;
		grid_t             grid;
	} cfg_t;

	// One byte after the position walk, before address arithmetic.
	typedef struct packed {
		logic              write;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              err;
		logic [CH_W-1:0]   ch;
		logic [PIX_W-1:0]  px;
		logic [PIX_W-1:0]  py;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} walk_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_TILE_DIM)) begin
			r = DIM_W'(MAX_TILE_DIM);
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > CNT_W'(MAX_TILES)) begin
			r = CNT_W'(MAX_TILES);
		end
		return r;
	endfunction

	// The grid grows as 2x1, 2x2, 3x2, 3x3, ... and stops at the first size
	// that holds n tiles. Scanning from the largest side down lets the
	// smallest fitting size win; within one side the k by k-1 shape comes first.
	function automatic grid_t grid_for(input logic [CNT_W-1:0] n);
		grid_t g;
		int    k;
		g.cols = GRID_W'(1);
		g.rows = GRID_W'(1);
		if (n > CNT_W'(1)) begin
			for (k = MAX_SIDE; k >= 2; k--) begin
				if (int'(n) <= k * k) begin
					g.cols = GRID_W'(k);
					g.rows = GRID_W'(k);
				end
				if (int'(n) <= k * (k - 1)) begin
					g.cols = GRID_W'(k);
					g.rows = GRID_W'(k - 1);
				end
			end
		end
		return g;
	endfunction

endpackage

### hw/rtl/sstp_cfg.sv
// ----------------------------------------------------------------------------
// Sprite sheet tile packer configuration registers
// Holds the clamped tile size and tile count and the grid derived from them.
// ----------------------------------------------------------------------------
module sstp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  sstp_pkg::reg_idx_t            cfg_index,
	input  logic [sstp_pkg::DIM_W-1:0]    cfg_data,
	output sstp_pkg::cfg_t                cfg
);

	sstp_pkg::cfg_t cfg_q;

	// The grid is recomputed in the same cycle as a tile count write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_w    <= sstp_pkg::DIM_W'(1);
			cfg_q.tile_h    <= sstp_pkg::DIM_W'(1);
			cfg_q.count     <= sstp_pkg::CNT_W'(1);
			cfg_q.grid.cols <= sstp_pkg::GRID_W'(1);
			cfg_q.grid.rows <= sstp_pkg::GRID_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sstp_pkg::REG_TILE_WIDTH: begin
					cfg_q.tile_w <= sstp_pkg::clamp_dim(cfg_data);
				end
				sstp_pkg::REG_TILE_HEIGHT: begin
					cfg_q.tile_h <= sstp_pkg::clamp_dim(cfg_data);
				end
				sstp_pkg::REG_TILE_COUNT: begin
					cfg_q.count <= sstp_pkg::clamp_count(cfg_data[sstp_pkg::CNT_W-1:0]);
					cfg_q.grid  <= sstp_pkg::grid_for(
						sstp_pkg::clamp_count(cfg_data[sstp_pkg::CNT_W-1:0]));
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/sstp_walk.sv
// ----------------------------------------------------------------------------
// Sprite sheet tile packer position walk
// Accepts source bytes, checks the tile size, and steps the channel, pixel,
// line and tile counters. Registers the byte and its position for the
// address stage.
// ----------------------------------------------------------------------------
module sstp_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sstp_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sstp_pkg::BYTE_W-1:0]   byte_value,
	input  logic [sstp_pkg::DIM_W-1:0]    src_width,
	input  logic [sstp_pkg::DIM_W-1:0]    src_height,
	input  logic                          s1_take,
	output logic                          valid_s1,
	output sstp_pkg::walk_t               item_s1
);

	logic [sstp_pkg::CNT_W-1:0] tile_index_q;
	logic [sstp_pkg::COL_W-1:0] tile_column_q;
	logic [sstp_pkg::ROW_W-1:0] tile_row_q;
	logic [sstp_pkg::PIX_W-1:0] pixel_x_q;
	logic [sstp_pkg::PIX_W-1:0] pixel_y_q;
	logic [sstp_pkg::CH_W-1:0]  channel_q;
	logic                       error_q;

	logic                       accept;
	logic                       active;
	logic                       mismatch;
	logic                       advance;
	logic [sstp_pkg::DIM_W-1:0] px_inc;
	logic [sstp_pkg::DIM_W-1:0] py_inc;
	logic [sstp_pkg::CNT_W:0]   idx_inc;
	logic [sstp_pkg::GRID_W-1:0] col_inc;
	logic                       ch_wrap;
	logic                       px_wrap;
	logic                       py_wrap;
	logic                       col_wrap;
	sstp_pkg::walk_t            item_d;

	assign in_ready = !valid_s1 || s1_take;
	assign accept   = in_valid && in_ready;

	// The counters stop once all tiles are placed or after a size mismatch.
	assign active   = !error_q && (tile_index_q < cfg.count);
	assign mismatch = (src_width != cfg.tile_w) || (src_height != cfg.tile_h);
	assign advance  = accept && active && !mismatch;

	assign px_inc   = sstp_pkg::DIM_W'(pixel_x_q) + sstp_pkg::DIM_W'(1);
	assign py_inc   = sstp_pkg::DIM_W'(pixel_y_q) + sstp_pkg::DIM_W'(1);
	assign idx_inc  = (sstp_pkg::CNT_W+1)'(tile_index_q) + (sstp_pkg::CNT_W+1)'(1);
	assign col_inc  = sstp_pkg::GRID_W'(tile_column_q) + sstp_pkg::GRID_W'(1);

	assign ch_wrap  = (channel_q == sstp_pkg::LAST_CHANNEL);
	assign px_wrap  = (px_inc >= cfg.tile_w);
	assign py_wrap  = (py_inc >= cfg.tile_h);
	assign col_wrap = (col_inc >= cfg.grid.cols);

	always_comb begin
		item_d       = '0;
		item_d.write = active && !mismatch;
		item_d.data  = byte_value;
		item_d.err   = error_q || (active && mismatch);
		item_d.ch    = channel_q;
		item_d.px    = pixel_x_q;
		item_d.py    = pixel_y_q;
		item_d.col   = tile_column_q;
		item_d.row   = tile_row_q;
		item_d.last  = active && !mismatch && ch_wrap
			&& (idx_inc == (sstp_pkg::CNT_W+1)'(cfg.count))
			&& (px_inc == cfg.tile_w) && (py_inc == cfg.tile_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			tile_index_q  <= '0;
			tile_column_q <= '0;
			tile_row_q    <= '0;
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
			channel_q     <= '0;
			error_q       <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept && active && mismatch) begin
				error_q <= 1'b1;
			end
			if (advance) begin
				channel_q <= channel_q + sstp_pkg::CH_W'(1);
				if (ch_wrap) begin
					if (px_wrap) begin
						pixel_x_q <= '0;
						if (py_wrap) begin
							pixel_y_q    <= '0;
							tile_index_q <= idx_inc[sstp_pkg::CNT_W-1:0];
							if (col_wrap) begin
								tile_column_q <= '0;
								tile_row_q    <= tile_row_q + sstp_pkg::ROW_W'(1);
							end else begin
								tile_column_q <= col_inc[sstp_pkg::COL_W-1:0];
							end
						end else begin
							pixel_y_q <= py_inc[sstp_pkg::PIX_W-1:0];
						end
					end else begin
						pixel_x_q <= px_inc[sstp_pkg::PIX_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

### hw/rtl/sstp_addr.sv
// ----------------------------------------------------------------------------
// Sprite sheet tile packer address stages
// Turns a tile position into a sheet byte address in two registered steps
// and holds the finished result for the output channel.
// ----------------------------------------------------------------------------
module sstp_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sstp_pkg::cfg_t                cfg,
	input  logic                          valid_s1,
	input  sstp_pkg::walk_t               item_s1,
	output logic                          s1_take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          write_valid,
	output logic [sstp_pkg::ADDR_W-1:0]   dest_address,
	output logic [sstp_pkg::BYTE_W-1:0]   byte_out,
	output logic                          last,
	output logic                          size_error
);

	logic                        valid_s2;
	logic                        write_s2;
	logic [sstp_pkg::BYTE_W-1:0] data_s2;
	logic                        last_s2;
	logic                        err_s2;
	logic [sstp_pkg::CH_W-1:0]   ch_s2;
	logic [sstp_pkg::Y_W-1:0]    y_s2;
	logic [sstp_pkg::X_W-1:0]    x_s2;
	logic [sstp_pkg::SW_W-1:0]   sw_s2;

	logic                        write_q;
	logic [sstp_pkg::ADDR_W-1:0] addr_q;
	logic [sstp_pkg::BYTE_W-1:0] data_q;
	logic                        last_q;
	logic                        err_q;

	logic                        s2_move;
	logic                        out_move;
	logic [sstp_pkg::Y_W-2:0]    y_mul;
	logic [sstp_pkg::X_W-2:0]    x_mul;
	logic [sstp_pkg::SW_W-1:0]   sw_mul;
	logic [sstp_pkg::LIN_W-1:0]  lin_mul;
	logic [sstp_pkg::LIN_W-1:0]  lin;

	assign out_move = !out_valid || out_ready;
	assign s2_move  = !valid_s2 || out_move;
	assign s1_take  = s2_move;

	// Sheet coordinates of the byte's pixel and the sheet width in pixels.
	assign y_mul  = (sstp_pkg::Y_W-1)'(item_s1.row) * (sstp_pkg::Y_W-1)'(cfg.tile_h);
	assign x_mul  = (sstp_pkg::X_W-1)'(item_s1.col) * (sstp_pkg::X_W-1)'(cfg.tile_w);
	assign sw_mul = sstp_pkg::SW_W'(cfg.grid.cols) * sstp_pkg::SW_W'(cfg.tile_w);

	// Only the low address bits survive, so the row product is cut early.
	assign lin_mul = sstp_pkg::LIN_W'(y_s2) * sstp_pkg::LIN_W'(sw_s2);
	assign lin     = lin_mul + sstp_pkg::LIN_W'(x_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s2_move) begin
				valid_s2 <= valid_s1;
			end
			if (out_move) begin
				out_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && valid_s1) begin
			write_s2 <= item_s1.write;
			data_s2  <= item_s1.data;
			last_s2  <= item_s1.last;
			err_s2   <= item_s1.err;
			ch_s2    <= item_s1.ch;
			y_s2     <= sstp_pkg::Y_W'(y_mul) + sstp_pkg::Y_W'(item_s1.py);
			x_s2     <= sstp_pkg::X_W'(x_mul) + sstp_pkg::X_W'(item_s1.px);
			sw_s2    <= sw_mul;
		end
		if (out_move && valid_s2) begin
			write_q <= write_s2;
			err_q   <= err_s2;
			if (write_s2) begin
				addr_q <= {lin, ch_s2};
				data_q <= data_s2;
				last_q <= last_s2;
			end else begin
				addr_q <= '0;
				data_q <= '0;
				last_q <= 1'b0;
			end
		end
	end

	assign write_valid  = write_q;
	assign dest_address = addr_q;
	assign byte_out     = data_q;
	assign last         = last_q;
	assign size_error   = err_q;

endmodule

### hw/rtl/sprite_sheet_tile_packer_core.sv
// ----------------------------------------------------------------------------
// Sprite sheet tile packer core
// Places the bytes of equally sized RGBA tiles into a near-square sheet grid
// and reports the sheet byte address of each one.
// ----------------------------------------------------------------------------
// Pipeline: three register stages: position walk, sheet coordinates, address.
// Throughput: one byte per cycle while out_ready does not stall the output;
// the address arithmetic is split over two stages so no stage feeds one
// product into another.
// Reset: asynchronous; tile size 1x1, tile count 1, grid 1x1, counters and
// the sticky size error cleared. No clearing pass is needed.
module sprite_sheet_tile_packer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sstp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [sstp_pkg::DIM_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sstp_pkg::BYTE_W-1:0]   byte_value,
	input  logic [sstp_pkg::DIM_W-1:0]    src_width,
	input  logic [sstp_pkg::DIM_W-1:0]    src_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          write_valid,
	output logic [sstp_pkg::ADDR_W-1:0]   dest_address,
	output logic [sstp_pkg::BYTE_W-1:0]   byte_out,
	output logic [sstp_pkg::GRID_W-1:0]   sheet_columns,
	output logic [sstp_pkg::GRID_W-1:0]   sheet_rows,
	output logic                          last,
	output logic                          size_error
);

	sstp_pkg::cfg_t  cfg;
	sstp_pkg::walk_t item_s1;
	logic            valid_s1;
	logic            s1_take;

	sstp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sstp_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.src_width  (src_width),
		.src_height (src_height),
		.s1_take    (s1_take),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	sstp_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.s1_take      (s1_take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_valid  (write_valid),
		.dest_address (dest_address),
		.byte_out     (byte_out),
		.last         (last),
		.size_error   (size_error)
	);

	// The grid must only change while the block is idle; the block itself does not enforce this. It is reported live.
	assign sheet_columns = cfg.grid.cols;
	assign sheet_rows    = cfg.grid.rows;

endmodule
